// ===== sv/tagged_value_stream_decoder_top_defines.svh =====
// Assertion macros for the tagged value stream decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TAGGED_VALUE_STREAM_DECODER_TOP_DEFINES_SVH
`define TAGGED_VALUE_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TVSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tvsd assertion failed");
`define TVSD_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tvsd assertion failed");
`else
`define TVSD_ASSERT(label, clk, rst_n, prop)
`define TVSD_ASSERT_NORST(label, clk, prop)
`endif

`endif

// ===== sv/tvsd_pkg.sv =====
// Package for the tagged value stream decoder: widths, tag flags, codes and the phase type.
// Standalone; used by tagged_value_stream_decoder_top.
`default_nettype none

package tvsd_pkg;

  localparam int POS_W = 32;
  localparam int BUF_W = 32;
  localparam int VAL_W = 64;
  localparam int CMP_W = (POS_W > BUF_W) ? POS_W : BUF_W;

  localparam logic [7:0] FLAG_NEGATE = 8'h10;
  localparam logic [7:0] FLAG_BLOB   = 8'h20;
  localparam logic [7:0] SIZE_MASK   = 8'h0F;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_VALUE = 2'd1,
    PH_DATA  = 2'd2,
    PH_ERROR = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_AFTER_END     = 2'd0,
    ERR_VALUE_OVERRUN = 2'd1,
    ERR_BAD_SIZE      = 2'd2,
    ERR_BLOB_OVERRUN  = 2'd3
  } err_code_t;

endpackage

`default_nettype wire

// ===== sv/tagged_value_stream_decoder_top.sv =====
// An input beat reaches its result beat through the input register, then the result register.
// Throughput: one input beat per cycle unless a result waits untaken; bytes that give no result count too.
// While a result waits to be taken, a new beat can enter an empty input register but is not decoded.
// Reset (rst_n low, synchronous) returns to tag decoding, clears position and length, sticky error.
// Depends on tvsd_pkg and tagged_value_stream_decoder_top_defines.svh.
`default_nettype none
`include "tagged_value_stream_decoder_top_defines.svh"

module tagged_value_stream_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tvsd_pkg::BUF_W-1:0] cfg_wr_data,   // buffer_length
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,      // [7:0] in_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [63:0] value, [71:64] data_byte, [73:72] error_code, [79:74] zero
  output logic [79:0]                     out_tdata,
  output logic [1:0]                      out_tuser,     // [1:0] kind
  output logic                            out_tlast      // last_of_blob
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       fire;

  // Decoder state
  tvsd_pkg::phase_t               phase_r, phase_nxt;
  logic                           negate_r, negate_nxt;
  logic                           blob_r, blob_nxt;
  logic [3:0]                     size_r, size_nxt;
  logic [3:0]                     taken_r, taken_nxt;
  logic [tvsd_pkg::VAL_W-1:0]     acc_r, acc_nxt;
  logic [tvsd_pkg::VAL_W-1:0]     remain_r, remain_nxt;
  logic [tvsd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [tvsd_pkg::BUF_W-1:0]     buf_len_r;

  // Result register
  logic                           out_valid_r;
  tvsd_pkg::kind_t                kind_r, kind_nxt;
  logic [tvsd_pkg::VAL_W-1:0]     value_r, value_nxt;
  logic [7:0]                     data_r, data_nxt;
  tvsd_pkg::err_code_t            err_r, err_nxt;
  logic                           last_r, last_nxt;
  logic                           emit;

  // Datapath helpers
  logic [3:0]                     tag_size;
  logic [tvsd_pkg::CMP_W-1:0]     pos_ext, pos_adv_ext, len_ext, blob_avail;
  logic [tvsd_pkg::CMP_W:0]       tag_reach;
  logic [tvsd_pkg::POS_W-1:0]     pos_adv;
  logic [5:0]                     lane_shift;
  logic [tvsd_pkg::VAL_W-1:0]     acc_new, val_final;
  logic [3:0]                     taken_new;
  logic                           tag_past_end, tag_overrun, tag_bad_size;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  assign tag_size     = in_byte_r[3:0] & tvsd_pkg::SIZE_MASK[3:0];
  assign pos_ext      = tvsd_pkg::CMP_W'(pos_r);
  assign len_ext      = tvsd_pkg::CMP_W'(buf_len_r);
  assign pos_adv      = pos_r + tvsd_pkg::POS_W'(1);
  assign pos_adv_ext  = tvsd_pkg::CMP_W'(pos_adv);
  assign tag_past_end = pos_ext >= len_ext;
  // More value bytes than remain after the tag: position + size reaches the length.
  assign tag_reach    = {1'b0, pos_ext} + (tvsd_pkg::CMP_W + 1)'(tag_size);
  assign tag_overrun  = tag_reach >= {1'b0, len_ext};
  assign tag_bad_size = !((tag_size == 4'd1) || (tag_size == 4'd2) ||
                          (tag_size == 4'd4) || (tag_size == 4'd8));

  assign lane_shift = {taken_r[2:0], 3'b000};
  assign acc_new    = acc_r | (tvsd_pkg::VAL_W'(in_byte_r) << lane_shift);
  assign taken_new  = taken_r + 4'd1;
  assign val_final  = negate_r ? (tvsd_pkg::VAL_W'(0) - acc_new) : acc_new;
  assign blob_avail = (pos_adv_ext >= len_ext) ? '0 : (len_ext - pos_adv_ext);

  always_comb begin
    phase_nxt  = phase_r;
    negate_nxt = negate_r;
    blob_nxt   = blob_r;
    size_nxt   = size_r;
    taken_nxt  = taken_r;
    acc_nxt    = acc_r;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    emit       = 1'b0;
    kind_nxt   = tvsd_pkg::KIND_ERROR;
    value_nxt  = '0;
    data_nxt   = '0;
    err_nxt    = tvsd_pkg::ERR_AFTER_END;
    last_nxt   = 1'b0;
    if (fire) begin
      unique case (phase_r)
        tvsd_pkg::PH_TAG: begin
          priority if (tag_past_end) begin
            phase_nxt = tvsd_pkg::PH_ERROR;
            emit      = 1'b1;
            err_nxt   = tvsd_pkg::ERR_AFTER_END;
          end else if (tag_overrun) begin
            phase_nxt = tvsd_pkg::PH_ERROR;
            emit      = 1'b1;
            err_nxt   = tvsd_pkg::ERR_VALUE_OVERRUN;
          end else if (tag_bad_size) begin
            phase_nxt = tvsd_pkg::PH_ERROR;
            emit      = 1'b1;
            err_nxt   = tvsd_pkg::ERR_BAD_SIZE;
          end else begin
            pos_nxt    = pos_adv;
            negate_nxt = (in_byte_r & tvsd_pkg::FLAG_NEGATE) != 8'h00;
            blob_nxt   = (in_byte_r & tvsd_pkg::FLAG_BLOB) != 8'h00;
            size_nxt   = tag_size;
            taken_nxt  = '0;
            acc_nxt    = '0;
            phase_nxt  = tvsd_pkg::PH_VALUE;
          end
        end
        tvsd_pkg::PH_VALUE: begin
          acc_nxt   = acc_new;
          taken_nxt = taken_new;
          pos_nxt   = pos_adv;
          if (taken_new >= size_r) begin
            phase_nxt = tvsd_pkg::PH_TAG;
            emit      = 1'b1;
            if (!blob_r) begin
              kind_nxt  = tvsd_pkg::KIND_INT;
              value_nxt = val_final;
            end else if (val_final[tvsd_pkg::VAL_W-1] ||
                         (val_final > tvsd_pkg::VAL_W'(blob_avail))) begin
              // A negative length counts as an overrun as well.
              phase_nxt = tvsd_pkg::PH_ERROR;
              err_nxt   = tvsd_pkg::ERR_BLOB_OVERRUN;
            end else begin
              kind_nxt  = tvsd_pkg::KIND_HEADER;
              value_nxt = val_final;
              last_nxt  = val_final == '0;
              if (val_final != '0) begin
                remain_nxt = val_final;
                phase_nxt  = tvsd_pkg::PH_DATA;
              end
            end
          end
        end
        tvsd_pkg::PH_DATA: begin
          pos_nxt    = pos_adv;
          remain_nxt = remain_r - tvsd_pkg::VAL_W'(1);
          emit       = 1'b1;
          kind_nxt   = tvsd_pkg::KIND_DATA;
          data_nxt   = in_byte_r;
          last_nxt   = remain_r == tvsd_pkg::VAL_W'(1);
          if (remain_r == tvsd_pkg::VAL_W'(1)) begin
            phase_nxt = tvsd_pkg::PH_TAG;
          end
        end
        tvsd_pkg::PH_ERROR: begin
          emit    = 1'b1;
          err_nxt = tvsd_pkg::ERR_AFTER_END;
        end
        default: begin
          phase_nxt = tvsd_pkg::PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tvsd_pkg::PH_TAG;
      negate_r    <= 1'b0;
      blob_r      <= 1'b0;
      size_r      <= '0;
      taken_r     <= '0;
      acc_r       <= '0;
      remain_r    <= '0;
      pos_r       <= '0;
      buf_len_r   <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      negate_r <= negate_nxt;
      blob_r   <= blob_nxt;
      size_r   <= size_nxt;
      taken_r  <= taken_nxt;
      acc_r    <= acc_nxt;
      remain_r <= remain_nxt;
      pos_r    <= pos_nxt;
      if (cfg_wr_en) begin
        buf_len_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (fire && emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      data_r  <= data_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, err_r, data_r, value_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  // Once failed, the decoder never leaves the error phase.
  `TVSD_ASSERT(a_error_sticky, clk, rst_n, (phase_r == tvsd_pkg::PH_ERROR) |=> (phase_r == tvsd_pkg::PH_ERROR))
  // A pending error result implies the decoder has entered the error phase.
  `TVSD_ASSERT(a_error_result_phase, clk, rst_n, (out_valid_r && (kind_r == tvsd_pkg::KIND_ERROR)) |-> (phase_r == tvsd_pkg::PH_ERROR))
  // While collecting value bytes, fewer than the tag size have been taken.
  `TVSD_ASSERT(a_value_count, clk, rst_n, (phase_r == tvsd_pkg::PH_VALUE) |-> (taken_r < size_r))
  // Blob data phase always has payload left to pass on.
  `TVSD_ASSERT(a_blob_remaining, clk, rst_n, (phase_r == tvsd_pkg::PH_DATA) |-> (remain_r != '0))
  // Nothing is emitted while the result register holds a beat that is not taken.
  `TVSD_ASSERT_NORST(a_no_overwrite, clk, (rst_n && out_valid_r && !out_tready) |-> !fire)

endmodule

`default_nettype wire

// ===== tb/tb_tagged_value_stream_decoder_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tagged_value_stream_decoder_top: directed rows, then random
// well-formed tagged streams under varying idle and stall rates, then one sticky error case.
// Depends on tvsd_pkg and the decoder RTL only.

module tb_tagged_value_stream_decoder_top;
  import tvsd_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int NUM_DIRECTED  = 27;
  localparam int RANDOM_BYTES  = 870;
  localparam int ROUND_BYTES   = 110;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [7:0]  data_byte;
    err_code_t   err;
    logic        last;
  } dec_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [31:0] data;
    logic        typed;
    dec_result_t res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [BUF_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [79:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  // Decoder state as the testbench sees it.
  phase_t            dec_phase = PH_TAG;
  logic              neg_flag = 1'b0;
  logic              blob_pend = 1'b0;
  logic [3:0]        val_size = '0;
  logic [3:0]        val_count = '0;
  logic [63:0]       val_acc = '0;
  logic [63:0]       blob_left = '0;
  logic [POS_W-1:0]  rd_pos = '0;
  logic [BUF_W-1:0]  buf_len = '0;

  dec_result_t       decoded_results[$];
  dir_row_t          directed_rows[NUM_DIRECTED];
  int unsigned       in_idle_pct = 0;
  int unsigned       out_stall_pct = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       lengths_written = 0;
  int unsigned       fail_count = 0;
  int unsigned       beats_by_kind[4] = '{0, 0, 0, 0};

  tagged_value_stream_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("%0t: timed out waiting for the decoder", $time);
    $display("** tagged_value_stream_decoder_top: FAILED **");
    $finish;
  end

  function automatic bit stick_error(input err_code_t code, output dec_result_t res);
    dec_phase = PH_ERROR;
    res = '0;
    res.kind = KIND_ERROR;
    res.err = code;
    return 1'b1;
  endfunction

  // Advances the decoder state by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, output dec_result_t res);
    logic [3:0]  sz;
    logic [63:0] room;
    logic [63:0] v;
    res = '0;
    sz = 4'(b & SIZE_MASK);
    case (dec_phase)
      PH_TAG: begin
        if (rd_pos >= buf_len) return stick_error(ERR_AFTER_END, res);
        room = 64'(buf_len) - 64'(rd_pos) - 64'd1;
        // The overrun check takes priority over the size check.
        if (64'(sz) > room) return stick_error(ERR_VALUE_OVERRUN, res);
        if (sz != 4'd1 && sz != 4'd2 && sz != 4'd4 && sz != 4'd8)
          return stick_error(ERR_BAD_SIZE, res);
        rd_pos = rd_pos + 1'b1;
        neg_flag = |(b & FLAG_NEGATE);
        blob_pend = |(b & FLAG_BLOB);
        val_size = sz;
        val_count = '0;
        val_acc = '0;
        dec_phase = PH_VALUE;
        return 1'b0;
      end
      PH_VALUE: begin
        val_acc = val_acc | (64'(b) << (8 * val_count[2:0]));
        val_count = val_count + 1'b1;
        rd_pos = rd_pos + 1'b1;
        if (val_count < val_size) return 1'b0;
        v = neg_flag ? -val_acc : val_acc;
        dec_phase = PH_TAG;
        if (!blob_pend) begin
          res.kind = KIND_INT;
          res.value = v;
          return 1'b1;
        end
        // A length written below the position leaves nothing for the blob.
        room = (rd_pos >= buf_len) ? 64'd0 : 64'(buf_len - rd_pos);
        if (v[63] || v > room) return stick_error(ERR_BLOB_OVERRUN, res);
        res.kind = KIND_HEADER;
        res.value = v;
        res.last = (v == 64'd0);
        if (v != 64'd0) begin
          blob_left = v;
          dec_phase = PH_DATA;
        end
        return 1'b1;
      end
      PH_DATA: begin
        rd_pos = rd_pos + 1'b1;
        blob_left = blob_left - 1'b1;
        if (blob_left == 64'd0) dec_phase = PH_TAG;
        res.kind = KIND_DATA;
        res.data_byte = b;
        res.last = (blob_left == 64'd0);
        return 1'b1;
      end
      default: return stick_error(ERR_AFTER_END, res);
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [31:0] len);
    dir_row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.data = len;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.op = ROW_BYTE;
    r.data = 32'(b);
    return r;
  endfunction

  function automatic dir_row_t checked_row(input logic [7:0] b, input kind_t k,
                                           input logic [63:0] v, input logic l);
    dir_row_t r;
    r = byte_row(b);
    r.typed = 1'b1;
    r.res.kind = k;
    r.res.value = v;
    r.res.last = l;
    return r;
  endfunction

  // Holds the beat until accepted, then records what the decoder should produce for it.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input dec_result_t typed_res = '0);
    dec_result_t res;
    bit          has_res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    has_res = decode_byte(b, res);
    if (typed) decoded_results.push_back(typed_res);
    else if (has_res) decoded_results.push_back(res);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    buf_len = len;
    lengths_written++;
  endtask

  // One well-formed item that fits in what is left of the buffer.
  task automatic send_random_item();
    logic [63:0] room;
    logic [63:0] spare;
    logic [63:0] val;
    logic [7:0]  tag;
    int          nbytes;
    int          blob_len;
    int          lim;
    bit          blob;
    bit          neg;
    room = 64'(buf_len) - 64'(rd_pos) - 64'd1;
    do nbytes = 1 << $urandom_range(3); while (64'(nbytes) > room);
    if (room <= 64'd8 && $urandom_range(1) == 1)
      nbytes = (room >= 64'd8) ? 8 : (room >= 64'd4) ? 4 : (room >= 64'd2) ? 2 : 1;
    blob = ($urandom_range(99) < 30);
    blob_len = 0;
    if (blob) begin
      spare = room - 64'(nbytes);
      lim = (spare > 64'd20) ? 20 : int'(spare);
      case ($urandom_range(3))
        0: blob_len = 0;
        1: blob_len = lim;
        default: blob_len = $urandom_range(lim);
      endcase
      val = 64'(blob_len);
      // Only a zero length may carry the negate flag without overrunning.
      neg = (blob_len == 0) && ($urandom_range(1) == 1);
    end else begin
      neg = ($urandom_range(1) == 1);
      case ($urandom_range(9))
        0: val = '0;
        1: val = '1;
        default: val = {$urandom, $urandom};
      endcase
    end
    tag = 8'(nbytes) | 8'($urandom_range(3) << 6);
    if (blob) tag = tag | FLAG_BLOB;
    if (neg) tag = tag | FLAG_NEGATE;
    send_byte(tag);
    for (int i = 0; i < nbytes; i++) send_byte(val[8*i +: 8]);
    for (int i = 0; i < blob_len; i++) send_byte(8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_results.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing outstanding, tuser %h tdata %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = decoded_results.pop_front();
        beats_by_kind[out_tuser]++;
        check_field("kind", 64'(want.kind), 64'(out_tuser));
        check_field("value", want.value, out_tdata[63:0]);
        check_field("data_byte", 64'(want.data_byte), 64'(out_tdata[71:64]));
        check_field("error_code", 64'(want.err), 64'(out_tdata[73:72]));
        check_field("tdata padding", 64'd0, 64'(out_tdata[79:74]));
        check_field("last_of_blob", 64'(want.last), 64'(out_tlast));
      end
    end
  end

  initial begin
    dir_row_t    row;
    err_code_t   closing_case;
    logic [7:0]  upper;
    int unsigned round_no;
    int unsigned round_end;
    int unsigned sz;

    directed_rows = '{
      cfg_row(32'hFFFF_FFFF),
      byte_row(8'h01), checked_row(8'h7F, KIND_INT, 64'h7F, 1'b0),
      // Negated most negative value wraps onto itself; the top two tag bits are ignored.
      byte_row(8'hD8), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      checked_row(8'h80, KIND_INT, 64'h8000_0000_0000_0000, 1'b0),
      byte_row(8'h24), byte_row(8'h03), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      byte_row(8'hAA), byte_row(8'h55), byte_row(8'hFF),
      byte_row(8'h31), checked_row(8'h00, KIND_HEADER, 64'd0, 1'b1),
      // Length cut to zero between the tag and its value: an empty blob still passes.
      byte_row(8'h22), cfg_row(32'h0000_0000),
      byte_row(8'h00), checked_row(8'h00, KIND_HEADER, 64'd0, 1'b1),
      cfg_row(32'hFFFF_FFFF)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        settle();
        write_length(row.data);
      end else begin
        send_byte(row.data[7:0], row.typed, row.res);
      end
    end

    round_no = 0;
    while (bytes_sent < NUM_DIRECTED + RANDOM_BYTES) begin
      case (round_no % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 88; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 88; end
        default: begin in_idle_pct = 38; out_stall_pct = 38; end
      endcase
      settle();
      if ($urandom_range(3) == 0) write_length(32'hFFFF_FFFF);
      else write_length(rd_pos + 32'($urandom_range(160, 40)));
      round_end = bytes_sent + ROUND_BYTES;
      while (bytes_sent < round_end && 64'(rd_pos) + 64'd2 <= 64'(buf_len))
        send_random_item();
      round_no++;
    end

    // Errors stick until reset and reset happens once, so the run ends with a single
    // failure case picked at random, followed by bytes that must each report an after-end error.
    closing_case = err_code_t'($urandom_range(3));
    in_idle_pct = 38;
    out_stall_pct = 38;
    upper = 8'($urandom_range(3) << 6);
    settle();
    case (closing_case)
      ERR_AFTER_END: begin
        write_length(rd_pos);
        send_byte(upper | 8'h01);
      end
      ERR_VALUE_OVERRUN: begin
        write_length(rd_pos + 32'd2);
        case ($urandom_range(2))
          0: sz = 4;
          1: sz = 8;
          default: sz = 15;
        endcase
        send_byte(upper | 8'($urandom_range(3) << 4) | 8'(sz));
      end
      ERR_BAD_SIZE: begin
        write_length(32'hFFFF_FFFF);
        do sz = $urandom_range(15); while (sz == 1 || sz == 2 || sz == 4 || sz == 8);
        send_byte(upper | 8'($urandom_range(3) << 4) | 8'(sz));
      end
      default: begin
        write_length(rd_pos + 32'd4);
        if ($urandom_range(1) == 1) begin
          send_byte(upper | FLAG_BLOB | 8'h01);
          send_byte(8'h03);
        end else begin
          send_byte(upper | FLAG_BLOB | FLAG_NEGATE | 8'h01);
          send_byte(8'h05);
        end
      end
    endcase
    repeat (6) send_byte(8'($urandom_range(255)));
    settle();

    $display("Decoded %0d beats over %0d length settings: %0d integers, %0d blob headers,",
             bytes_sent, lengths_written, beats_by_kind[KIND_INT], beats_by_kind[KIND_HEADER]);
    $display("%0d blob data beats and %0d error beats; closing failure case %s.",
             beats_by_kind[KIND_DATA], beats_by_kind[KIND_ERROR], closing_case.name());
    if (fail_count == 0) begin
      $display("** tagged_value_stream_decoder_top: PASSED **");
    end else begin
      $display("** tagged_value_stream_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== tagged_value_stream_decoder_top.f =====
+incdir+sv
sv/tvsd_pkg.sv
sv/tagged_value_stream_decoder_top.sv
tb/tb_tagged_value_stream_decoder_top.sv
